FILE: rtl/core/mtp_pkg.sv
// Shared types, constants and arithmetic helpers for the Morton tile RGB565 packer.
`timescale 1ns / 1ps

package mtp_pkg;

    // Coordinate and channel widths
    localparam int COORD_W   = 6;
    localparam int CHAN_W    = 8;
    localparam int TA_W      = 4;
    localparam int INDEX_W   = 12;
    localparam int COLOR_W   = 16;

    // Default row limit and register reset value
    localparam int          MAX_SIDE_DEF = 64;
    localparam logic [TA_W-1:0] TA_RESET = 4'd6;

    // One input request: pixel coordinates and RGBA8888 color
    typedef struct packed {
        logic [COORD_W-1:0] pixel_x;
        logic [COORD_W-1:0] pixel_y;
        logic [CHAN_W-1:0]  red;
        logic [CHAN_W-1:0]  green;
        logic [CHAN_W-1:0]  blue;
        logic [CHAN_W-1:0]  alpha;
    } t_pixel;

    // One result request
    typedef struct packed {
        logic [INDEX_W-1:0] tiled_index;
        logic [COLOR_W-1:0] colour565;
        logic               out_of_range;
    } t_result;

    // Interleave low three bits of x and y: x0,y0,x1,y1,x2,y2 from bit 0 up
    function automatic logic [5:0] morton6(input logic [2:0] x, input logic [2:0] y);
        return {y[2], x[2], y[1], x[1], y[0], x[0]};
    endfunction

    // Exact floor(p / 255) for p below 65280: (p + 1 + (p >> 8)) >> 8
    function automatic logic [CHAN_W-1:0] div255(input logic [15:0] p);
        logic [16:0] sum;
        sum = {1'b0, p} + 17'd1 + {9'd0, p[15:8]};
        return sum[15:8];
    endfunction

endpackage

FILE: rtl/core/mtp_if.sv
// Valid/ready channel interfaces for pixel and result requests.
`timescale 1ns / 1ps

interface mtp_pixel_if;
    logic                       valid;
    logic                       ready;
    logic [mtp_pkg::COORD_W-1:0] pixel_x;
    logic [mtp_pkg::COORD_W-1:0] pixel_y;
    logic [mtp_pkg::CHAN_W-1:0]  red;
    logic [mtp_pkg::CHAN_W-1:0]  green;
    logic [mtp_pkg::CHAN_W-1:0]  blue;
    logic [mtp_pkg::CHAN_W-1:0]  alpha;

    modport source (output valid, pixel_x, pixel_y, red, green, blue, alpha, input ready);
    modport sink   (input valid, pixel_x, pixel_y, red, green, blue, alpha, output ready);
endinterface

interface mtp_result_if;
    logic                        valid;
    logic                        ready;
    logic [mtp_pkg::INDEX_W-1:0] tiled_index;
    logic [mtp_pkg::COLOR_W-1:0] colour565;
    logic                        out_of_range;

    modport source (output valid, tiled_index, colour565, out_of_range, input ready);
    modport sink   (input valid, tiled_index, colour565, out_of_range, output ready);
endinterface

FILE: rtl/core/mtp_index.sv
// Tiled Morton word index and range flag for one pixel.
`timescale 1ns / 1ps

module mtp_index #(
    parameter int MAX_SIDE = mtp_pkg::MAX_SIDE_DEF
) (
    input  logic [mtp_pkg::COORD_W-1:0] i_x,
    input  logic [mtp_pkg::COORD_W-1:0] i_y,
    input  logic [mtp_pkg::TA_W-1:0]    i_tiles_across,
    output logic [mtp_pkg::INDEX_W-1:0] o_index,
    output logic                        o_out_of_range
);
    import mtp_pkg::*;

    logic [6:0] tile_row_base;
    logic [5:0] tile;
    logic [6:0] x_ext;
    logic [6:0] y_ext;
    logic [6:0] x_limit;

    // Tile number: tile row times tiles across plus tile column
    assign tile_row_base = i_y[5:3] * i_tiles_across;
    assign tile          = 6'({1'b0, tile_row_base} + {5'd0, i_x[5:3]});

    // 64 words per tile, wrap to 12 bits
    assign o_index = {tile, morton6(i_x[2:0], i_y[2:0])};

    // Column beyond configured width, or row beyond the side limit
    assign x_ext   = {1'b0, i_x};
    assign y_ext   = {1'b0, i_y};
    assign x_limit = {i_tiles_across, 3'b000};
    assign o_out_of_range = (x_ext >= x_limit) || (y_ext >= 7'(MAX_SIDE));

endmodule

FILE: rtl/core/mtp_color.sv
// Alpha premultiply and RGB565 pack for one pixel.
`timescale 1ns / 1ps

module mtp_color (
    input  logic [mtp_pkg::CHAN_W-1:0]  i_red,
    input  logic [mtp_pkg::CHAN_W-1:0]  i_green,
    input  logic [mtp_pkg::CHAN_W-1:0]  i_blue,
    input  logic [mtp_pkg::CHAN_W-1:0]  i_alpha,
    output logic [mtp_pkg::COLOR_W-1:0] o_colour565
);
    import mtp_pkg::*;

    logic [15:0] prod_r;
    logic [15:0] prod_g;
    logic [15:0] prod_b;
    logic [7:0]  pm_r;
    logic [7:0]  pm_g;
    logic [7:0]  pm_b;

    // 8x8 products against alpha
    assign prod_r = i_red   * i_alpha;
    assign prod_g = i_green * i_alpha;
    assign prod_b = i_blue  * i_alpha;

    // floor(c*a/255)
    assign pm_r = div255(prod_r);
    assign pm_g = div255(prod_g);
    assign pm_b = div255(prod_b);

    // Keep top 5/6/5 bits
    assign o_colour565 = {pm_r[7:3], pm_g[7:2], pm_b[7:3]};

endmodule

FILE: rtl/core/morton_tile_rgb565_packer_unit.sv
// Top level of the Morton tile RGB565 packer: input register, compute, result register.
//
//  channel  | dir | protocol     | payload
//  ---------+-----+--------------+-------------------------------------------
//  i_pix    | in  | valid/ready  | pixel_x, pixel_y, red, green, blue, alpha
//  o_res    | out | valid/ready  | tiled_index, colour565, out_of_range
//  i_cfg_*  | in  | write enable | tiles_across (4 bits)
//
// One request per clock sustained while o_res accepts; a request passes from the input register to the result register.
// The path between the input and result registers holds one 8x8 multiply per channel
// and the divide-by-255 add.
// A stalled result holds its register; the input register still fills behind it, so
// the input side stops only when both registers are full.
// Synchronous active-low reset empties both registers and sets tiles_across to 6.
`timescale 1ns / 1ps

module morton_tile_rgb565_packer_unit #(
    parameter int MAX_SIDE = mtp_pkg::MAX_SIDE_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [mtp_pkg::TA_W-1:0]  i_cfg_wdata,
    mtp_pixel_if.sink                 i_pix,
    mtp_result_if.source              o_res
);
    import mtp_pkg::*;

    logic [TA_W-1:0] r_tiles_across;
    t_pixel          r_in;
    logic            r_in_valid;
    t_result         r_out;
    logic            r_out_valid;
    t_result         n_out;
    logic            in_fire;
    logic            s1_advance;

    // Handshake control
    assign s1_advance  = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_pix.ready = !r_in_valid || s1_advance;
    assign in_fire     = i_pix.valid && i_pix.ready;

    // Config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tiles_across <= TA_RESET;
        end else if (i_cfg_we) begin
            r_tiles_across <= i_cfg_wdata;
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_fire) begin
            r_in_valid <= 1'b1;
        end else if (s1_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in.pixel_x <= i_pix.pixel_x;
            r_in.pixel_y <= i_pix.pixel_y;
            r_in.red     <= i_pix.red;
            r_in.green   <= i_pix.green;
            r_in.blue    <= i_pix.blue;
            r_in.alpha   <= i_pix.alpha;
        end
    end

    // Compute
    mtp_index #(
        .MAX_SIDE(MAX_SIDE)
    ) u_index (
        .i_x            (r_in.pixel_x),
        .i_y            (r_in.pixel_y),
        .i_tiles_across (r_tiles_across),
        .o_index        (n_out.tiled_index),
        .o_out_of_range (n_out.out_of_range)
    );

    mtp_color u_color (
        .i_red       (r_in.red),
        .i_green     (r_in.green),
        .i_blue      (r_in.blue),
        .i_alpha     (r_in.alpha),
        .o_colour565 (n_out.colour565)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_advance) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_advance) begin
            r_out <= n_out;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.tiled_index  = r_out.tiled_index;
    assign o_res.colour565    = r_out.colour565;
    assign o_res.out_of_range = r_out.out_of_range;

endmodule
